FILE: design/sprite_part_quad_setup_defines.svh
// Assertion macros shared by the sprite part quad setup RTL.
`ifndef SPRITE_PART_QUAD_SETUP_DEFINES_SVH
`define SPRITE_PART_QUAD_SETUP_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define SPQS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define SPQS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: design/spqs_pkg.sv
// Types and constants of the sprite part quad setup block.
`default_nettype none

package spqs_pkg;

  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned IN_DATA_W = 120;
  localparam int unsigned OUT_DATA_W = 128;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_X = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Y = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FACING_LEFT = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_PALETTE_BASE = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_Z_PRIORITY = 3'd4;

  // Bit positions within part_flags.
  localparam int unsigned FLAG_VFLIP = 0;
  localparam int unsigned FLAG_HFLIP = 1;
  localparam int unsigned FLAG_TRIM_RIGHT = 2;
  localparam int unsigned FLAG_TRIM_BOTTOM = 3;
  localparam int unsigned FLAG_TRIM_LEFT = 4;
  localparam int unsigned FLAG_TRIM_TOP = 5;

  typedef struct packed {
    logic signed [15:0] origin_x;
    logic signed [15:0] origin_y;
    logic               facing_left;
    logic [15:0]        palette_base;
    logic [15:0]        z_priority;
  } cfg_t;

  typedef struct packed {
    logic [5:0]         part_flags;
    logic signed [15:0] offset_x;
    logic signed [15:0] offset_y;
    logic signed [15:0] part_width;
    logic signed [15:0] part_height;
    logic [15:0]        clut_offset;
    logic [7:0]         tex_u_start;
    logic [7:0]         tex_v_start;
    logic [7:0]         tex_u_end;
    logic [7:0]         tex_v_end;
  } part_t;

  typedef struct packed {
    logic signed [15:0] x_left;
    logic signed [15:0] x_right;
    logic signed [15:0] y_top;
    logic signed [15:0] y_bottom;
    logic [7:0]         u_left;
    logic [7:0]         u_right;
    logic [7:0]         v_top;
    logic [7:0]         v_bottom;
    logic [15:0]        colour_table;
    logic [15:0]        draw_priority;
  } quad_t;

endpackage

`default_nettype wire

FILE: design/sprite_part_quad_setup.sv
// Top level of the sprite part quad setup block: handshake, registers and configuration.
// The block turns each sprite part item into one textured quad placed around a configured
// anchor, one result item for every input item. It is a two-register pipeline: an item is
// captured in the input register, all its arithmetic (trim, anchor offset, mirroring, texture
// flips, palette and priority adds) is done by short logic in spqs_calc, and the result is
// captured in the output register. A new item can be accepted in every cycle while in_tready
// is high; the input register empties into the output register whenever the latter is empty
// or being taken, so a stall on the output side holds at most two items before in_tready
// drops. Configuration registers are written through the cfg_ port and should only change
// while no item is in flight. Writes to an index beyond the register list are ignored.
`default_nettype none
`include "sprite_part_quad_setup_defines.svh"

module sprite_part_quad_setup
  import spqs_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  // Configuration write port.
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
  // Input items.
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  // tdata from bit 0: part_flags[5:0], offset_x[21:6], offset_y[37:22], part_width[53:38],
  // part_height[69:54], clut_offset[85:70], tex_u_start[93:86], tex_v_start[101:94],
  // tex_u_end[109:102], tex_v_end[117:110], zero fill[119:118]
  input  wire logic [IN_DATA_W-1:0]  in_tdata,
  // Result items.
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  // tdata from bit 0: x_left[15:0], x_right[31:16], y_top[47:32], y_bottom[63:48],
  // u_left[71:64], u_right[79:72], v_top[87:80], v_bottom[95:88],
  // colour_table[111:96], draw_priority[127:112]
  output logic [OUT_DATA_W-1:0]      out_tdata
);

  // Configuration registers.
  cfg_t  cfg_r;
  cfg_t  cfg_nxt;

  // Input register stage.
  logic  s1_valid_r;
  logic  s1_valid_nxt;
  part_t s1_part_r;
  part_t in_part;

  // Output register stage.
  logic  out_valid_r;
  logic  out_valid_nxt;
  quad_t out_quad_r;
  quad_t calc_quad;

  logic  in_accept;
  logic  out_advance;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        CFG_ORIGIN_X:     cfg_nxt.origin_x     = cfg_wdata;
        CFG_ORIGIN_Y:     cfg_nxt.origin_y     = cfg_wdata;
        CFG_FACING_LEFT:  cfg_nxt.facing_left  = cfg_wdata[0];
        CFG_PALETTE_BASE: cfg_nxt.palette_base = cfg_wdata;
        CFG_Z_PRIORITY:   cfg_nxt.z_priority   = cfg_wdata;
        default:          cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // Unpack the input item.
  always_comb begin
    in_part.part_flags  = in_tdata[5:0];
    in_part.offset_x    = in_tdata[21:6];
    in_part.offset_y    = in_tdata[37:22];
    in_part.part_width  = in_tdata[53:38];
    in_part.part_height = in_tdata[69:54];
    in_part.clut_offset = in_tdata[85:70];
    in_part.tex_u_start = in_tdata[93:86];
    in_part.tex_v_start = in_tdata[101:94];
    in_part.tex_u_end   = in_tdata[109:102];
    in_part.tex_v_end   = in_tdata[117:110];
  end

  // The output register can take a new item when it is empty or its item is being taken;
  // the input register can then hand on its item, so it is free for the next one.
  always_comb begin
    out_advance   = !out_valid_r || out_tready;
    in_tready     = !s1_valid_r || out_advance;
    in_accept     = in_tvalid && in_tready;
    s1_valid_nxt  = in_accept || (s1_valid_r && !out_advance);
    out_valid_nxt = out_advance ? s1_valid_r : out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_part_r <= in_part;
    end
    if (out_advance && s1_valid_r) begin
      out_quad_r <= calc_quad;
    end
  end

  spqs_calc u_calc (
    .part (s1_part_r),
    .cfg  (cfg_r),
    .quad (calc_quad)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_quad_r.draw_priority, out_quad_r.colour_table,
                       out_quad_r.v_bottom, out_quad_r.v_top,
                       out_quad_r.u_right, out_quad_r.u_left,
                       out_quad_r.y_bottom, out_quad_r.y_top,
                       out_quad_r.x_right, out_quad_r.x_left};

  // An item in the input register moves on whenever the output side has room.
  `SPQS_ASSERT_NEXT(a_s1_moves_on, clk, rst_n, s1_valid_r && !out_valid_r, out_valid_r,
    "item in input register did not move to an empty output register")
  // An accepted item always lands in the input register.
  `SPQS_ASSERT_NEXT(a_accept_fills, clk, rst_n, in_tvalid && in_tready, s1_valid_r,
    "accepted item was not captured")
  // Back-pressure only appears when both registers hold items.
  `SPQS_ASSERT_NOW(a_stall_full, clk, rst_n, !in_tready, s1_valid_r && out_valid_r,
    "input stalled while the pipeline had room")
  // A taken result is replaced by the waiting item in the next cycle.
  `SPQS_ASSERT_NEXT(a_refill, clk, rst_n, out_valid_r && out_tready && s1_valid_r,
    out_valid_r, "waiting item was lost after a result was taken")

endmodule

`default_nettype wire

FILE: design/spqs_calc.sv
// Quad edge, texture, palette and priority arithmetic for one sprite part.
`default_nettype none

module spqs_calc
  import spqs_pkg::*;
(
  input  part_t part,
  input  cfg_t  cfg,
  output quad_t quad
);

  logic        vflip;
  logic        hbit;
  logic        trim_r;
  logic        trim_b;
  logic        trim_l;
  logic        trim_t;
  logic        dx_inc;
  logic        dy_inc;
  logic [15:0] w_adj;
  logic [15:0] h_adj;
  logic [15:0] dx;
  logic [15:0] dy;
  logic [15:0] x_base;
  logic [15:0] y_base;
  logic [7:0]  u0;
  logic [7:0]  u1;
  logic [7:0]  v0;
  logic [7:0]  v1;

  always_comb begin
    vflip  = part.part_flags[FLAG_VFLIP];
    hbit   = part.part_flags[FLAG_HFLIP];
    trim_r = part.part_flags[FLAG_TRIM_RIGHT];
    trim_b = part.part_flags[FLAG_TRIM_BOTTOM];
    trim_l = part.part_flags[FLAG_TRIM_LEFT];
    trim_t = part.part_flags[FLAG_TRIM_TOP];

    // A trimmed edge that lands on the left or top side after flipping moves the anchor by one pixel.
    dx_inc = (trim_r & hbit) | (trim_l & ~hbit);
    dy_inc = (trim_b & vflip) | (trim_t & ~vflip);

    w_adj = 16'(part.part_width) - {15'd0, trim_r} - {15'd0, trim_l};
    h_adj = 16'(part.part_height) - {15'd0, trim_b} - {15'd0, trim_t};
    dx    = 16'(part.offset_x) + {15'd0, dx_inc};
    dy    = 16'(part.offset_y) + {15'd0, dy_inc};

    u0 = part.tex_u_start + {7'd0, trim_l};
    u1 = part.tex_u_end - {7'd0, trim_r};
    v0 = part.tex_v_start + {7'd0, trim_t};
    v1 = part.tex_v_end - {7'd0, trim_b};

    y_base = 16'(cfg.origin_y) + dy;
    quad.y_top    = y_base;
    quad.y_bottom = y_base + h_adj;

    // Facing left mirrors the part about the anchor.
    if (cfg.facing_left) begin
      x_base = 16'(cfg.origin_x) - dx;
      quad.x_left  = x_base - w_adj + 16'd1;
      quad.x_right = x_base + 16'd1;
    end else begin
      x_base = 16'(cfg.origin_x) + dx;
      quad.x_left  = x_base;
      quad.x_right = x_base + w_adj;
    end

    if (hbit | cfg.facing_left) begin
      quad.u_left  = u1 - 8'd1;
      quad.u_right = u0 - 8'd1;
    end else begin
      quad.u_left  = u0;
      quad.u_right = u1;
    end

    if (vflip) begin
      quad.v_top    = v1 - 8'd1;
      quad.v_bottom = v0 - 8'd1;
    end else begin
      quad.v_top    = v0;
      quad.v_bottom = v1;
    end

    quad.colour_table  = cfg.palette_base + part.clut_offset;
    quad.draw_priority = cfg.z_priority + 16'd1;
  end

endmodule

`default_nettype wire
